/* rtl/drt_pkg.sv */
// shared types, constants and rectangle helpers for the layer dirty rectangle tracker
// no dependencies; every other file imports this package
package drt_pkg;

  localparam int MAX_LAYERS   = 8;
  localparam int COORD_BITS   = 16;
  localparam int LAYER_IDX_W  = 3;
  localparam int VIS_W        = 8;
  localparam int LCOUNT_W     = 4;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 16;
  localparam int PTR_W        = (MAX_LAYERS > 1) ? $clog2(MAX_LAYERS) : 1;
  localparam int CNT_W        = ($clog2(MAX_LAYERS + 1) > LCOUNT_W) ?
                                $clog2(MAX_LAYERS + 1) : LCOUNT_W;
  localparam int AREA_W       = 2 * COORD_BITS;

  typedef logic [COORD_BITS-1:0] coord_t;
  typedef logic [PTR_W-1:0]      ptr_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t w;
    coord_t h;
  } rect_t;

  typedef enum logic [1:0] {
    OP_MARK    = 2'd0,
    OP_MARK_TR = 2'd1,
    OP_EVAL    = 2'd2,
    OP_CLEAR   = 2'd3
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LAYER_COUNT  = 2'd0,
    CFG_VISIBLE_MASK = 2'd1,
    CFG_SCREEN_W     = 2'd2,
    CFG_SCREEN_H     = 2'd3
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_MARK,
    ST_EVAL,
    ST_AREA,
    ST_FRAME,
    ST_CMP,
    ST_DONE
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic clr_acc;
    logic clr_all;
    logic mark_step;
    logic mark_force;
    logic eval_step;
    logic mul_area;
    logic mul_frame;
    logic set_scissor;
    logic capture;
    ptr_t ptr;
  } drt_cmd_t;

  // datapath to controller
  typedef struct packed {
    op_t  op;
    logic mark_ok;
    ptr_t target;
  } drt_status_t;

  function automatic logic rect_empty(rect_t r);
    return (r.w == '0) || (r.h == '0);
  endfunction

  // bounding-box union, right and bottom edges clamp at the coordinate limit
  function automatic rect_t rect_union(rect_t dst, rect_t src);
    rect_t            res;
    logic [COORD_BITS:0] edge_dr;
    logic [COORD_BITS:0] edge_sr;
    logic [COORD_BITS:0] edge_db;
    logic [COORD_BITS:0] edge_sb;
    logic [COORD_BITS:0] rmax;
    logic [COORD_BITS:0] bmax;
    coord_t           l;
    coord_t           t;
    coord_t           rc;
    coord_t           bc;
    edge_dr = {1'b0, dst.x} + {1'b0, dst.w};
    edge_sr = {1'b0, src.x} + {1'b0, src.w};
    edge_db = {1'b0, dst.y} + {1'b0, dst.h};
    edge_sb = {1'b0, src.y} + {1'b0, src.h};
    rmax    = (edge_sr > edge_dr) ? edge_sr : edge_dr;
    bmax    = (edge_sb > edge_db) ? edge_sb : edge_db;
    rc      = rmax[COORD_BITS] ? '1 : rmax[COORD_BITS-1:0];
    bc      = bmax[COORD_BITS] ? '1 : bmax[COORD_BITS-1:0];
    l       = (dst.x < src.x) ? dst.x : src.x;
    t       = (dst.y < src.y) ? dst.y : src.y;
    res.x   = l;
    res.y   = t;
    res.w   = (rc > l) ? (rc - l) : '0;
    res.h   = (bc > t) ? (bc - t) : '0;
    if (rect_empty(src)) begin
      res = dst;
    end else if (rect_empty(dst)) begin
      res = src;
    end
    return res;
  endfunction

endpackage

/* rtl/drt_if.sv */
// item and result channel interfaces of the layer dirty rectangle tracker
// depends on drt_pkg for widths
interface drt_item_if
  import drt_pkg::*;
;
  logic                   valid;
  logic                   ready;
  logic [1:0]             opcode;
  logic [LAYER_IDX_W-1:0] layer_index;
  logic [COORD_BITS-1:0]  rect_x;
  logic [COORD_BITS-1:0]  rect_y;
  logic [COORD_BITS-1:0]  rect_width;
  logic [COORD_BITS-1:0]  rect_height;

  modport source (
    output valid, opcode, layer_index, rect_x, rect_y, rect_width, rect_height,
    input  ready
  );
  modport sink (
    input  valid, opcode, layer_index, rect_x, rect_y, rect_width, rect_height,
    output ready
  );
endinterface

interface drt_result_if
  import drt_pkg::*;
;
  logic                  valid;
  logic                  ready;
  logic                  accepted;
  logic [COORD_BITS-1:0] merged_x;
  logic [COORD_BITS-1:0] merged_y;
  logic [COORD_BITS-1:0] merged_width;
  logic [COORD_BITS-1:0] merged_height;
  logic                  use_scissor;

  modport source (
    output valid, accepted, merged_x, merged_y, merged_width, merged_height, use_scissor,
    input  ready
  );
  modport sink (
    input  valid, accepted, merged_x, merged_y, merged_width, merged_height, use_scissor,
    output ready
  );
endinterface

/* rtl/layer_dirty_rect_tracker.sv */
// layer dirty rectangle tracker: one item at a time, one registered result per item
// mark runs the shared union unit on the target layer, transparent mark on layers 0 up
// to it, evaluate on all MAX_LAYERS layers then area, frame and compare; clear or a
// rejected mark goes straight to the result; next item taken once the result is valid
// a new item is taken while the previous result still waits in the output register
// synchronous active-high rst: registers 3/0/640/480, all rectangles and the flag zero
module layer_dirty_rect_tracker
  import drt_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  drt_item_if.sink              item,
  drt_result_if.source          result
);

  drt_cmd_t    cmd;
  drt_status_t status;

  // control: decode, layer walk, multiply steps, result handoff
  drt_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (item.valid),
    .in_ready  (item.ready),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .status    (status),
    .cmd       (cmd)
  );

  // datapath: config registers, layer store, union unit, scissor math
  drt_datapath u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .opcode        (item.opcode),
    .layer_index   (item.layer_index),
    .rect_x        (item.rect_x),
    .rect_y        (item.rect_y),
    .rect_width    (item.rect_width),
    .rect_height   (item.rect_height),
    .cmd           (cmd),
    .status        (status),
    .accepted      (result.accepted),
    .merged_x      (result.merged_x),
    .merged_y      (result.merged_y),
    .merged_width  (result.merged_width),
    .merged_height (result.merged_height),
    .use_scissor   (result.use_scissor)
  );

endmodule

/* rtl/drt_ctrl.sv */
// sequencing state machine of the layer dirty rectangle tracker
// depends on drt_pkg; drives drt_datapath through drt_cmd_t
module drt_ctrl
  import drt_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  output logic        out_valid,
  input  logic        out_ready,
  input  drt_status_t status,
  output drt_cmd_t    cmd
);

  state_t state;
  state_t state_next;
  ptr_t   ptr;
  ptr_t   ptr_next;
  logic   out_free;
  logic   ptr_at_target;
  logic   ptr_at_last;

  assign out_free      = !out_valid || out_ready;
  assign ptr_at_target = (ptr == status.target);
  assign ptr_at_last   = (ptr == PTR_W'(MAX_LAYERS - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      ptr   <= '0;
    end else begin
      state <= state_next;
      ptr   <= ptr_next;
    end
  end

  always_comb begin
    state_next = state;
    ptr_next   = ptr;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) state_next = ST_DECODE;
      end
      ST_DECODE: begin
        unique case (status.op)
          OP_MARK, OP_MARK_TR: begin
            state_next = status.mark_ok ? ST_MARK : ST_DONE;
            ptr_next   = (status.op == OP_MARK) ? status.target : '0;
          end
          OP_EVAL: begin
            state_next = ST_EVAL;
            ptr_next   = '0;
          end
          OP_CLEAR: state_next = ST_DONE;
          default:  state_next = ST_DONE;
        endcase
      end
      ST_MARK: begin
        ptr_next = ptr + 1'b1;
        if (ptr_at_target) state_next = ST_DONE;
      end
      ST_EVAL: begin
        ptr_next = ptr + 1'b1;
        if (ptr_at_last) state_next = ST_AREA;
      end
      ST_AREA:  state_next = ST_FRAME;
      ST_FRAME: state_next = ST_CMP;
      ST_CMP:   state_next = ST_DONE;
      ST_DONE: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    cmd.ptr  = ptr;
    in_ready = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ST_DECODE: begin
        cmd.clr_acc = (status.op == OP_EVAL);
        cmd.clr_all = (status.op == OP_CLEAR);
      end
      ST_MARK: begin
        cmd.mark_step  = 1'b1;
        cmd.mark_force = ptr_at_target;
      end
      ST_EVAL:  cmd.eval_step   = 1'b1;
      ST_AREA:  cmd.mul_area    = 1'b1;
      ST_FRAME: cmd.mul_frame   = 1'b1;
      ST_CMP:   cmd.set_scissor = 1'b1;
      ST_DONE:  cmd.capture     = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.capture) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule

/* rtl/drt_datapath.sv */
// configuration, layer rectangle store, union unit, area multiplier and result register
// depends on drt_pkg; commanded by drt_ctrl
module drt_datapath
  import drt_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic [1:0]             opcode,
  input  logic [LAYER_IDX_W-1:0] layer_index,
  input  coord_t                 rect_x,
  input  coord_t                 rect_y,
  input  coord_t                 rect_width,
  input  coord_t                 rect_height,
  input  drt_cmd_t               cmd,
  output drt_status_t            status,
  output logic                   accepted,
  output coord_t                 merged_x,
  output coord_t                 merged_y,
  output coord_t                 merged_width,
  output coord_t                 merged_height,
  output logic                   use_scissor
);

  logic [LCOUNT_W-1:0]    layer_count;
  logic [VIS_W-1:0]       visible_mask;
  coord_t                 screen_width;
  coord_t                 screen_height;

  op_t                    item_op;
  logic [LAYER_IDX_W-1:0] item_idx;
  rect_t                  item_rect;

  rect_t                  layer_rects [MAX_LAYERS];
  rect_t                  merged_rect;
  logic                   scissor_flag;
  logic [AREA_W-1:0]      area;
  logic [AREA_W-1:0]      frame;

  logic                   lc_write;
  logic                   wipe;
  logic [CNT_W-1:0]       active_n;
  rect_t                  sel_rect;
  rect_t                  dst_op;
  rect_t                  src_op;
  rect_t                  union_res;
  logic                   layer_we;
  logic [AREA_W+1:0]      frame_x3;
  logic [AREA_W-1:0]      frame_lim;
  logic                   is_mark;

  // config port
  assign lc_write = cfg_we && (cfg_reg_t'(cfg_index) == CFG_LAYER_COUNT);
  assign wipe     = lc_write || cmd.clr_all;

  always_ff @(posedge clk) begin
    if (rst) begin
      layer_count   <= LCOUNT_W'(3);
      visible_mask  <= '0;
      screen_width  <= COORD_BITS'(640);
      screen_height <= COORD_BITS'(480);
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_LAYER_COUNT:  layer_count   <= cfg_data[LCOUNT_W-1:0];
        CFG_VISIBLE_MASK: visible_mask  <= cfg_data[VIS_W-1:0];
        CFG_SCREEN_W:     screen_width  <= cfg_data[COORD_BITS-1:0];
        CFG_SCREEN_H:     screen_height <= cfg_data[COORD_BITS-1:0];
        default: ;
      endcase
    end
  end

  // item latch
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_op     <= op_t'(opcode);
      item_idx    <= layer_index;
      item_rect.x <= rect_x;
      item_rect.y <= rect_y;
      item_rect.w <= rect_width;
      item_rect.h <= rect_height;
    end
  end

  assign active_n = (CNT_W'(layer_count) < CNT_W'(MAX_LAYERS)) ?
                    CNT_W'(layer_count) : CNT_W'(MAX_LAYERS);
  assign is_mark  = (item_op == OP_MARK) || (item_op == OP_MARK_TR);

  assign status.op      = item_op;
  assign status.mark_ok = (CNT_W'(item_idx) < active_n) && !rect_empty(item_rect);
  assign status.target  = PTR_W'(item_idx);

  // shared union unit
  assign sel_rect  = layer_rects[cmd.ptr];
  assign dst_op    = cmd.eval_step ? merged_rect : sel_rect;
  assign src_op    = cmd.eval_step ? sel_rect : item_rect;
  assign union_res = rect_union(dst_op, src_op);
  assign layer_we  = cmd.mark_step &&
                     (cmd.mark_force || visible_mask[LAYER_IDX_W'(cmd.ptr)]);

  always_ff @(posedge clk) begin
    if (rst || wipe) begin
      for (int i = 0; i < MAX_LAYERS; i++) begin
        layer_rects[i] <= '0;
      end
    end else if (layer_we) begin
      layer_rects[cmd.ptr] <= union_res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || wipe || cmd.clr_acc) begin
      merged_rect <= '0;
    end else if (cmd.eval_step) begin
      merged_rect <= union_res;
    end
  end

  // scissor decision: non-empty merged area <= 3/4 of the frame, both products exact
  always_ff @(posedge clk) begin
    if (cmd.mul_area) begin
      area <= AREA_W'(merged_rect.w) * AREA_W'(merged_rect.h);
    end
    if (cmd.mul_frame) begin
      frame <= AREA_W'(screen_width) * AREA_W'(screen_height);
    end
  end

  assign frame_x3  = {2'b00, frame} + {1'b0, frame, 1'b0};
  assign frame_lim = frame_x3[AREA_W+1:2];

  always_ff @(posedge clk) begin
    if (rst || wipe) begin
      scissor_flag <= 1'b0;
    end else if (cmd.set_scissor) begin
      scissor_flag <= !rect_empty(merged_rect) && (area <= frame_lim);
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      accepted      <= !(is_mark && !status.mark_ok);
      merged_x      <= merged_rect.x;
      merged_y      <= merged_rect.y;
      merged_width  <= merged_rect.w;
      merged_height <= merged_rect.h;
      use_scissor   <= scissor_flag;
    end
  end

endmodule
